>>> hdl/piecewise_linear_interpolator_defines.svh
// Assertion macros shared by the interpolator RTL.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// A property that must hold at every sampled clock edge.
`define PLI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that, once seen, forces another one on the next clock edge.
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pli_pkg.sv
// ---------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared word types, field codes, register map and controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

	localparam int VAL_W      = 32;
	localparam int ENTRY_W    = 2 * VAL_W;
	localparam int MAX_POINTS = 16;
	localparam int CFG_W      = 5;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [CFG_W-1:0] POINTS_RESET = 5'd2;

	// Register index, taken from the word address of the APB port.
	localparam logic REG_POINTS = 1'b0;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] RS_INTERP = 2'd0;
	localparam logic [1:0] RS_FIRST  = 2'd1;
	localparam logic [1:0] RS_LAST   = 2'd2;

	typedef struct packed {
		logic                    kind;
		logic [3:0]              point_index;
		logic signed [VAL_W-1:0] key_value;
		logic signed [VAL_W-1:0] sample_value;
	} pli_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [1:0]              range_status;
	} pli_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT
	} pli_state_t;

endpackage

`default_nettype wire

>>> hdl/pli_table_mem.sv
// ---------------------------------------------------------------------------
// Breakpoint table memory
// One write port and one read port; each entry holds x in the upper half
// and y in the lower half. Read data is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_table_mem #(
	parameter int DEPTH = pli_pkg::MAX_POINTS,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [IDX_W-1:0]            waddr,
	input  wire logic [pli_pkg::ENTRY_W-1:0] wdata,
	input  wire logic [IDX_W-1:0]            raddr,
	output      logic [pli_pkg::ENTRY_W-1:0] rdata
);
	import pli_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/pli_divider.sv
// ---------------------------------------------------------------------------
// Restoring divider
// Divides a double-width unsigned dividend by a single-width divisor, one
// quotient bit per cycle. The quotient must fit in a single word, which
// holds when the upper half of the dividend is below the divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [2*pli_pkg::VAL_W-1:0]   dividend,
	input  wire logic [pli_pkg::VAL_W-1:0]     divisor,
	output      logic                          done,
	output      logic [pli_pkg::VAL_W-1:0]     quotient
);
	import pli_pkg::*;

	localparam int STEP_W = $clog2(VAL_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [VAL_W-1:0]  div_q;
	logic [VAL_W:0]    trial;
	logic [VAL_W:0]    diff;
	logic              ge;
	logic [VAL_W-1:0]  rem_next;

	// The low dividend bits shift out of quo_q as quotient bits shift in.
	assign trial    = {rem_q, quo_q[VAL_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign ge       = trial >= {1'b0, div_q};
	assign rem_next = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(VAL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= dividend[2*VAL_W-1:VAL_W];
			quo_q <= dividend[VAL_W-1:0];
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[VAL_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> hdl/piecewise_linear_interpolator.sv
// ---------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table with a linear search and an iterative division stage.
// ---------------------------------------------------------------------------
// Usage:
// A word on item is taken at a rising edge where start is high and busy is
// low. A load word (kind 0) writes one breakpoint into the table in that same
// cycle and leaves busy low, so loads may follow back to back. A query word
// (kind 1) raises busy while the table is scanned from slot 0, one slot per
// cycle through the memory read port, then, if the key falls between two
// points, a multiply step and a restoring division. The division dominates
// the time that a query takes. The result word appears on result with
// result_strobe high for one cycle and stays there until the next result;
// the receiver cannot stall it. The user must write points_in_use over the
// APB port only while the block is idle; the block itself does not enforce
// this. Reset sets points_in_use to two and returns the control to idle;
// the table contents are undefined until loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "piecewise_linear_interpolator_defines.svh"

module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pli_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [pli_pkg::PDATA_W-1:0]   pwdata,
	output      logic [pli_pkg::PDATA_W-1:0]   prdata,
	output      logic                          pready,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire pli_pkg::pli_in_t              item,
	output      logic                          result_strobe,
	output      pli_pkg::pli_out_t             result
);
	import pli_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);

	pli_state_t         state_q, state_d;
	logic [CFG_W-1:0]   points_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   last_q;
	logic signed [VAL_W-1:0] key_q;
	logic [VAL_W-1:0]   x1_q, y1_q;
	logic [VAL_W-1:0]   dx_q, span_q, mag_q;
	logic               neg_q;
	logic [ENTRY_W-1:0] prod_q;
	logic               strobe_q;
	pli_out_t           res_q;

	logic               accept;
	logic               cfg_wr;
	logic               mem_we;
	logic [IDX_W-1:0]   raddr;
	logic [ENTRY_W-1:0] rdata;
	logic [VAL_W-1:0]   rd_x, rd_y;
	logic               hit;
	logic               at_last;
	logic               div_go;
	logic               div_done;
	logic [VAL_W-1:0]   quo;
	logic               out_valid;
	pli_out_t           out_word;
	logic [31:0]        n_pts;
	logic [VAL_W:0]     dx_full, span_full, dy_full, dy_abs;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POINTS);
	assign prdata = (paddr[2] == REG_POINTS) ? {{(PDATA_W-CFG_W){1'b0}}, points_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= POINTS_RESET;
		end else if (cfg_wr) begin
			points_q <= pwdata[CFG_W-1:0];
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign mem_we = accept && (item.kind == KIND_LOAD)
		&& ({28'd0, item.point_index} < 32'(MAX_POINTS));

	// Zero points count as one; counts beyond the table saturate.
	always_comb begin
		n_pts = {{(32-CFG_W){1'b0}}, points_q};
		if (n_pts == 32'd0) begin
			n_pts = 32'd1;
		end
		if (n_pts > 32'(MAX_POINTS)) begin
			n_pts = 32'(MAX_POINTS);
		end
	end

	pli_table_mem #(
		.DEPTH(MAX_POINTS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (IDX_W'(item.point_index)),
		.wdata ({item.key_value, item.sample_value}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_x    = rdata[ENTRY_W-1:VAL_W];
	assign rd_y    = rdata[VAL_W-1:0];
	assign hit     = $signed(rd_x) >= key_q;
	assign at_last = (idx_q == last_q);

	assign dx_full   = {key_q[VAL_W-1], key_q} - {x1_q[VAL_W-1], x1_q};
	assign span_full = {rd_x[VAL_W-1], rd_x} - {x1_q[VAL_W-1], x1_q};
	assign dy_full   = {rd_y[VAL_W-1], rd_y} - {y1_q[VAL_W-1], y1_q};
	assign dy_abs    = dy_full[VAL_W] ? (~dy_full + 1'b1) : dy_full;

	pli_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (prod_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The read port runs one slot ahead of the compare so the scan moves a
	// slot every cycle.
	always_comb begin
		state_d   = state_q;
		raddr     = idx_q + 1'b1;
		div_go    = 1'b0;
		out_valid = 1'b0;
		out_word  = '0;
		unique case (state_q)
			ST_IDLE: begin
				raddr = '0;
				if (accept && (item.kind == KIND_QUERY)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					if (idx_q == '0) begin
						state_d   = ST_IDLE;
						out_valid = 1'b1;
						out_word  = '{result_value: rd_y, range_status: RS_FIRST};
					end else begin
						state_d = ST_MUL;
					end
				end else if (at_last) begin
					state_d   = ST_IDLE;
					out_valid = 1'b1;
					out_word  = '{result_value: rd_y, range_status: RS_LAST};
				end
			end
			ST_MUL: begin
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_go  = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d   = ST_IDLE;
					out_valid = 1'b1;
					out_word  = '{result_value: neg_q ? (y1_q - quo) : (y1_q + quo),
						range_status: RS_INTERP};
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= out_valid;
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if ((state_q == ST_SEARCH) && !hit) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.kind == KIND_QUERY)) begin
			key_q  <= item.key_value;
			last_q <= IDX_W'(n_pts - 32'd1);
		end
		if ((state_q == ST_SEARCH) && !hit) begin
			x1_q <= rd_x;
			y1_q <= rd_y;
		end
		if ((state_q == ST_SEARCH) && hit) begin
			dx_q   <= dx_full[VAL_W-1:0];
			span_q <= span_full[VAL_W-1:0];
			mag_q  <= dy_abs[VAL_W-1:0];
			neg_q  <= dy_full[VAL_W];
		end
		if (state_q == ST_MUL) begin
			prod_q <= mag_q * dx_q;
		end
		if (out_valid) begin
			res_q <= out_word;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = res_q;

	`PLI_ASSERT_NEXT(a_strobe_single, result_strobe, !result_strobe, "result strobe held for two cycles")
	`PLI_ASSERT(a_strobe_after_busy, !result_strobe || $past(busy), "result without a query in progress")
	`PLI_ASSERT(a_write_when_idle, !mem_we || (state_q == ST_IDLE), "table written during a query")
	`PLI_ASSERT(a_div_done_waited, !div_done || (state_q == ST_DIV_WAIT), "division finished unexpectedly")

endmodule

`default_nettype wire
